/* hdl/bmp_stream_pixel_decoder_core_defines.svh */
// ----------------------------------------------------------------------------
// BMP stream pixel decoder: assertion macros
// Shared assertion helpers for the decoder top level. They sample on clk and
// are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BMP_STREAM_PIXEL_DECODER_CORE_DEFINES_SVH
`define BMP_STREAM_PIXEL_DECODER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMP_SPD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BMP_SPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bmp_spd_pkg.sv */
// ----------------------------------------------------------------------------
// BMP stream pixel decoder package
// Result kinds, output formats, the queued result record and default sizes.
// ----------------------------------------------------------------------------
package bmp_spd_pkg;

    // Default image size limits.
    localparam int DEFAULT_MAX_WIDTH  = 4096;
    localparam int DEFAULT_MAX_HEIGHT = 4096;

    // Depth of the queue between the parser and the output stage.
    localparam int QUEUE_DEPTH = 4;

    // Result kinds.
    localparam logic [1:0] KIND_PIXEL     = 2'd0;
    localparam logic [1:0] KIND_NOT_BMP   = 2'd1;
    localparam logic [1:0] KIND_BAD_DEPTH = 2'd2;
    localparam logic [1:0] KIND_RANGE     = 2'd3;

    // Output pixel formats.
    localparam logic [1:0] FMT_RGB565 = 2'd0;
    localparam logic [1:0] FMT_RGB888 = 2'd1;
    localparam logic [1:0] FMT_XRGB   = 2'd2;

    // One decoded result as it travels from the parser to the output stage.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
        logic        eoi;
    } rec_t;

    // Queue status seen by the parser and the output stage.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

/* hdl/bmp_spd_front.sv */
// ----------------------------------------------------------------------------
// BMP stream pixel decoder: byte parser
// Takes a byte per cycle (queue not full), parses the header, skips to pixel
// data and row padding, gathers B,G,R triplets, pushes pixel or error records.
// ----------------------------------------------------------------------------
module bmp_spd_front #(
    parameter int MAX_WIDTH  = bmp_spd_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmp_spd_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 in_byte,
    input  logic                       in_first,
    input  bmp_spd_pkg::queue_status_t q_status,
    output logic                       push,
    output bmp_spd_pkg::rec_t          push_rec
);
    import bmp_spd_pkg::*;

    localparam int W_W = $clog2(MAX_WIDTH + 1);
    localparam int H_W = $clog2(MAX_HEIGHT + 1);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_PAD    = 2'd2;
    localparam logic [1:0] PH_IDLE   = 2'd3;

    localparam logic [31:0] POS_SIG0  = 32'd0;
    localparam logic [31:0] POS_SIG1  = 32'd1;
    localparam logic [31:0] POS_OFF   = 32'd10;
    localparam logic [31:0] POS_WID   = 32'd18;
    localparam logic [31:0] POS_HGT   = 32'd22;
    localparam logic [31:0] POS_DEP   = 32'd28;
    localparam logic [31:0] POS_LAST  = 32'd29;
    localparam logic [7:0]  SIG_B     = 8'h42;
    localparam logic [7:0]  SIG_M     = 8'h4d;
    localparam logic [15:0] DEPTH_24  = 16'd24;

    logic [31:0]    pos_reg, pos_next;
    logic [W_W-1:0] width_reg, width_next;
    logic           width_big_reg, width_big_next;
    logic [H_W-1:0] height_reg, height_next;
    logic           height_big_reg, height_big_next;
    logic [15:0]    depth_reg, depth_next;
    logic [31:0]    offset_reg, offset_next;
    logic [1:0]     phase_reg, phase_next;
    logic [1:0]     bip_reg, bip_next;
    logic [7:0]     blue_reg, blue_next;
    logic [7:0]     green_reg, green_next;
    logic [W_W-1:0] col_reg, col_next;
    logic [H_W-1:0] row_reg, row_next;
    logic [1:0]     pad_reg, pad_next;

    logic           accept;
    logic [31:0]    e_pos;
    logic [1:0]     lane_off, lane_wid, lane_hgt;
    logic [31:0]    sh_off, sh_wid, sh_hgt, sh_dep;
    logic [W_W-1:0] col_inc;
    logic [H_W-1:0] row_inc;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    // Byte lanes of the little-endian header fields.
    assign e_pos    = in_first ? '0 : pos_reg;
    assign lane_off = 2'(e_pos - POS_OFF);
    assign lane_wid = 2'(e_pos - POS_WID);
    assign lane_hgt = 2'(e_pos - POS_HGT);
    assign sh_off   = 32'(in_byte) << {lane_off, 3'b000};
    assign sh_wid   = 32'(in_byte) << {lane_wid, 3'b000};
    assign sh_hgt   = 32'(in_byte) << {lane_hgt, 3'b000};
    assign sh_dep   = 32'(in_byte) << {e_pos[0], 3'b000};
    assign col_inc  = col_reg + 1'b1;
    assign row_inc  = row_reg + 1'b1;

    // Parser next state; a first byte starts from cleared state.
    always_comb
    begin
        pos_next        = pos_reg;
        width_next      = width_reg;
        width_big_next  = width_big_reg;
        height_next     = height_reg;
        height_big_next = height_big_reg;
        depth_next      = depth_reg;
        offset_next     = offset_reg;
        phase_next      = phase_reg;
        bip_next        = bip_reg;
        blue_next       = blue_reg;
        green_next      = green_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        pad_next        = pad_reg;
        push            = 1'b0;
        push_rec        = '0;
        push_rec.eoi    = 1'b1;
        if (accept)
        begin
            if (in_first)
            begin
                width_next      = '0;
                width_big_next  = 1'b0;
                height_next     = '0;
                height_big_next = 1'b0;
                depth_next      = '0;
                offset_next     = '0;
                phase_next      = PH_HEADER;
                bip_next        = '0;
                blue_next       = '0;
                green_next      = '0;
                col_next        = '0;
                row_next        = '0;
                pad_next        = '0;
            end
            if (e_pos != '1)
            begin
                pos_next = e_pos + 32'd1;
            end
            else
            begin
                pos_next = e_pos;
            end
            case (phase_next)
                PH_HEADER:
                begin
                    if (e_pos >= POS_OFF && e_pos <= POS_OFF + 32'd3)
                    begin
                        offset_next = offset_next | sh_off;
                    end
                    if (e_pos >= POS_WID && e_pos <= POS_WID + 32'd3)
                    begin
                        width_next     = width_next | sh_wid[W_W-1:0];
                        width_big_next = width_big_next || ((sh_wid >> W_W) != '0);
                    end
                    if (e_pos >= POS_HGT && e_pos <= POS_HGT + 32'd3)
                    begin
                        height_next     = height_next | sh_hgt[H_W-1:0];
                        height_big_next = height_big_next || ((sh_hgt >> H_W) != '0);
                    end
                    if (e_pos >= POS_DEP && e_pos <= POS_LAST)
                    begin
                        depth_next = depth_next | sh_dep[15:0];
                    end
                    if ((e_pos == POS_SIG0 && in_byte != SIG_B) ||
                        (e_pos == POS_SIG1 && in_byte != SIG_M))
                    begin
                        push          = 1'b1;
                        push_rec.kind = KIND_NOT_BMP;
                        phase_next    = PH_IDLE;
                    end
                    else if (e_pos == POS_LAST)
                    begin
                        if (depth_next != DEPTH_24)
                        begin
                            push          = 1'b1;
                            push_rec.kind = KIND_BAD_DEPTH;
                            phase_next    = PH_IDLE;
                        end
                        else if (width_next == '0 || width_big_next ||
                                 width_next > W_W'(MAX_WIDTH) ||
                                 height_next == '0 || height_big_next ||
                                 height_next > H_W'(MAX_HEIGHT) ||
                                 offset_next <= POS_LAST)
                        begin
                            push          = 1'b1;
                            push_rec.kind = KIND_RANGE;
                            phase_next    = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    if (e_pos >= offset_reg)
                    begin
                        case (bip_reg)
                            2'd0:
                            begin
                                blue_next = in_byte;
                                bip_next  = 2'd1;
                            end
                            2'd1:
                            begin
                                green_next = in_byte;
                                bip_next   = 2'd2;
                            end
                            default:
                            begin
                                bip_next        = 2'd0;
                                push            = 1'b1;
                                push_rec.kind   = KIND_PIXEL;
                                push_rec.red    = in_byte;
                                push_rec.green  = green_reg;
                                push_rec.blue   = blue_reg;
                                push_rec.column = 12'(col_reg);
                                push_rec.row    = 12'(height_reg - 1'b1 - row_reg);
                                push_rec.eoi    = 1'b0;
                                col_next        = col_inc;
                                if (col_inc == width_reg)
                                begin
                                    col_next = '0;
                                    row_next = row_inc;
                                    if (row_inc == height_reg)
                                    begin
                                        push_rec.eoi = 1'b1;
                                        phase_next   = PH_IDLE;
                                    end
                                    else
                                    begin
                                        pad_next = width_reg[1:0];
                                        if (width_reg[1:0] != 2'd0)
                                        begin
                                            phase_next = PH_PAD;
                                        end
                                    end
                                end
                            end
                        endcase
                    end
                end
                PH_PAD:
                begin
                    pad_next = pad_reg - 2'd1;
                    if (pad_reg == 2'd1)
                    begin
                        phase_next = PH_DATA;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            width_reg      <= '0;
            width_big_reg  <= 1'b0;
            height_reg     <= '0;
            height_big_reg <= 1'b0;
            depth_reg      <= '0;
            offset_reg     <= '0;
            phase_reg      <= PH_HEADER;
            bip_reg        <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            pad_reg        <= '0;
        end
        else
        begin
            pos_reg        <= pos_next;
            width_reg      <= width_next;
            width_big_reg  <= width_big_next;
            height_reg     <= height_next;
            height_big_reg <= height_big_next;
            depth_reg      <= depth_next;
            offset_reg     <= offset_next;
            phase_reg      <= phase_next;
            bip_reg        <= bip_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            pad_reg        <= pad_next;
        end
    end

    // Held color bytes of the pixel in progress.
    always_ff @(posedge clk)
    begin
        blue_reg  <= blue_next;
        green_reg <= green_next;
    end

endmodule

/* hdl/bmp_spd_fifo.sv */
// ----------------------------------------------------------------------------
// BMP stream pixel decoder: result queue
// A short register queue of result records between parser and output stage.
// DEPTH must be a power of two, at least two.
// ----------------------------------------------------------------------------
module bmp_spd_fifo #(
    parameter int DEPTH = bmp_spd_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  bmp_spd_pkg::rec_t          push_rec,
    input  logic                       pop,
    output bmp_spd_pkg::rec_t          head_rec,
    output bmp_spd_pkg::queue_status_t status
);
    import bmp_spd_pkg::*;

    localparam int AW = $clog2(DEPTH);

    rec_t          store_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;

    assign status.full  = (count_reg == (AW + 1)'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_rec     = store_reg[rd_ptr_reg];

    // Pointer and fill-count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

/* hdl/bmp_spd_back.sv */
// ----------------------------------------------------------------------------
// BMP stream pixel decoder: output stage
// Holds the format register, converts queued records to the selected pixel
// format and drives the registered result stream.
// ----------------------------------------------------------------------------
module bmp_spd_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fmt_we,
    input  logic [1:0]                 fmt_wdata,
    input  bmp_spd_pkg::queue_status_t q_status,
    input  bmp_spd_pkg::rec_t          head_rec,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [47:0]                out_data,
    output logic [1:0]                 out_kind,
    output logic                       out_last
);
    import bmp_spd_pkg::*;

    logic [1:0]  fmt_reg;
    logic        valid_reg, valid_next;
    logic [47:0] data_reg;
    logic [1:0]  kind_reg;
    logic        last_reg;
    logic [23:0] pix_value;

    assign pop        = !q_status.empty && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;
    assign out_kind   = kind_reg;
    assign out_last   = last_reg;

    // Pixel format conversion; error records carry zero colors.
    always_comb
    begin
        case (fmt_reg)
            FMT_RGB565:
                pix_value = {8'd0, head_rec.red[7:3], head_rec.green[7:2],
                             head_rec.blue[7:3]};
            default:
                pix_value = {head_rec.red, head_rec.green, head_rec.blue};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= FMT_RGB565;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (fmt_we)
            begin
                fmt_reg <= fmt_wdata;
            end
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= {head_rec.row, head_rec.column, pix_value};
            kind_reg <= head_rec.kind;
            last_reg <= head_rec.eoi;
        end
    end

endmodule

/* hdl/bmp_stream_pixel_decoder_core.sv */
// ----------------------------------------------------------------------------
// BMP stream pixel decoder core
// Decodes a 24-bit BMP byte stream into RGB565, packed RGB888 or XRGB pixels.
// ----------------------------------------------------------------------------
// The core takes one file byte per clock cycle (s_tuser[0] high marks the
// first byte of a new file) and gives at most one result word per byte: a
// pixel with its column and top-down row, or an error word that ends the
// file. The byte parser keeps up with the input at one word per cycle; its
// results pass through a four-word queue to a registered output stage: a
// result goes into the queue, then into the output register, and only then
// is offered on the master side. Input is refused only while the queue is
// full. out_format should be written only while no file is being decoded.
`include "bmp_stream_pixel_decoder_core_defines.svh"

module bmp_stream_pixel_decoder_core #(
    parameter int MAX_WIDTH  = bmp_spd_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmp_spd_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration.
    input  logic        out_format_we,
    input  logic [1:0]  out_format_wdata,
    // Byte input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] file_byte
    input  logic [0:0]  s_tuser,   // [0] first_byte
    // Result output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [23:0] pixel_value, [35:24] pixel_column,
                                   // [47:36] pixel_row
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast    // end_of_image
);
    import bmp_spd_pkg::*;

    queue_status_t q_status;
    logic          push;
    logic          pop;
    rec_t          push_rec;
    rec_t          head_rec;

    // Byte parser.
    bmp_spd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_first (s_tuser[0]),
        .q_status (q_status),
        .push     (push),
        .push_rec (push_rec)
    );

    // Result queue.
    bmp_spd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .status   (q_status)
    );

    // Output stage.
    bmp_spd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fmt_we    (out_format_we),
        .fmt_wdata (out_format_wdata),
        .q_status  (q_status),
        .head_rec  (head_rec),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_kind  (m_tuser),
        .out_last  (m_tlast)
    );

    // Checks.
    `BMP_SPD_ASSERT_SAME(a_no_push_when_full, push, !q_status.full,
        "result pushed into a full queue")
    `BMP_SPD_ASSERT_SAME(a_no_pop_when_empty, pop, !q_status.empty,
        "result popped from an empty queue")
    `BMP_SPD_ASSERT_SAME(a_error_word_shape, m_tvalid && m_tuser != KIND_PIXEL,
        m_tlast && m_tdata == '0, "error word must be zero and end the image")
    `BMP_SPD_ASSERT_NEXT(a_error_enters_idle, push && push_rec.kind != KIND_PIXEL,
        !push || s_tuser[0], "parser produced a result right after an error")

endmodule
